### src/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared types and constants for the glyph token tile layout block.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int GLYPH_SLOTS_DEF = 128;
  localparam int TILE_BYTES      = 32;
  localparam int HALF_STRIDE     = 2 * TILE_BYTES;
  localparam int FULL_STRIDE     = 4 * TILE_BYTES;

  localparam int GRID_COLS = 32;
  localparam int GRID_ROWS = 23;
  localparam logic [5:0] HIGH_ID_MASK = 6'h3f;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_STORE_HEADER = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HALF_TOTAL   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_NEWLINE      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_WIDE_MASK    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ASCII_BASE   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LINE_PITCH   = 3'd5;

  localparam logic [1:0] OP_PAGE   = 2'd0;
  localparam logic [1:0] OP_STRING = 2'd1;
  localparam logic [1:0] OP_TOKEN  = 2'd2;

  typedef struct packed {
    logic [23:0] glyph_byte_offset;
    logic [9:0]  slot_tile;
    logic [9:0]  map_position;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

### src/glyph_token_tile_layout.sv
// ----------------------------------------------------------------------------
// glyph_token_tile_layout
// Lays out a token stream on a 32x23 tile map, one halfcell result per slot.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_stall    operation start_row start_col token_byte
//  out       output     out_valid/out_stall  glyph_byte_offset slot_tile map_position last
//  cfg       input      cfg_en               cfg_index cfg_data
//
//  one input transaction per cycle while in_stall is low; its results enter the queue at
//  the same edge and leave on out behind any older results, one per cycle while out_stall
//  is low, so a wide glyph gives up to two results. in_stall rises while the four-entry
//  result queue holds more than two results. reset is synchronous and restores cursor,
//  slots and registers.
module glyph_token_tile_layout #(
  parameter int GLYPH_SLOTS = gtl_pkg::GLYPH_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_en,
  input  logic [gtl_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gtl_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 operation,
  input  logic [4:0]                 start_row,
  input  logic [4:0]                 start_col,
  input  logic [7:0]                 token_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [23:0]                glyph_byte_offset,
  output logic [9:0]                 slot_tile,
  output logic [9:0]                 map_position,
  output logic                       last
);

  logic             accept;
  gtl_pkg::push_t   push;
  gtl_pkg::result_t head;

  assign accept = in_valid && !in_stall;

  gtl_core #(
    .GLYPH_SLOTS(GLYPH_SLOTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .operation  (operation),
    .start_row  (start_row),
    .start_col  (start_col),
    .token_byte (token_byte),
    .push       (push)
  );

  gtl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign glyph_byte_offset = head.glyph_byte_offset;
  assign slot_tile         = head.slot_tile;
  assign map_position      = head.map_position;
  assign last              = head.last;

endmodule

### src/gtl_core.sv
// ----------------------------------------------------------------------------
// gtl_core
// Cursor, slot and configuration state; builds up to two results per token.
// ----------------------------------------------------------------------------
module gtl_core #(
  parameter int GLYPH_SLOTS = gtl_pkg::GLYPH_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_en,
  input  logic [gtl_pkg::CFG_AW-1:0] cfg_index,
  input  logic [gtl_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       accept,
  input  logic [1:0]                 operation,
  input  logic [4:0]                 start_row,
  input  logic [4:0]                 start_col,
  input  logic [7:0]                 token_byte,
  output gtl_pkg::push_t             push
);

  logic [15:0] store_header_bytes;
  logic [15:0] half_glyph_total;
  logic [7:0]  newline_code;
  logic [7:0]  wide_flag_mask;
  logic [7:0]  ascii_base;
  logic [3:0]  line_pitch_tiles;

  logic [7:0] cursor_row, cursor_row_next;
  logic [7:0] cursor_col, cursor_col_next;
  logic [4:0] line_start_col, line_start_col_next;
  logic       wide_pending, wide_pending_next;
  logic [5:0] wide_high_bits, wide_high_bits_next;
  logic [8:0] slot_count, slot_count_next;

  logic        is_tok, tok_nz, is_nl, is_wide_start, is_half, do_full;
  logic        row_ok, col_a_ok, col_b_ok;
  logic        place_a, place_b;
  logic [8:0]  slot_a;
  logic [8:0]  col_b;
  logic [13:0] full_id;
  logic [23:0] full_off0, full_off1, half_off;
  logic [7:0]  tok_rel;
  gtl_pkg::result_t res_a, res_b;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[8] ? 8'hff : s[7:0];
  endfunction

  function automatic logic [9:0] tile_of(input logic [8:0] s);
    tile_of = {s, 1'b0} + 10'd2;
  endfunction

  always_comb begin
    is_tok        = operation == gtl_pkg::OP_TOKEN;
    tok_nz        = token_byte != 8'd0;
    do_full       = is_tok && wide_pending;
    is_nl         = is_tok && !wide_pending && tok_nz && token_byte == newline_code;
    is_wide_start = is_tok && !wide_pending && tok_nz && token_byte != newline_code &&
                    (token_byte & wide_flag_mask) != 8'd0;
    is_half       = is_tok && !wide_pending && tok_nz && token_byte != newline_code &&
                    (token_byte & wide_flag_mask) == 8'd0 && token_byte >= ascii_base;

    full_id   = {wide_high_bits, token_byte};
    full_off0 = 24'(store_header_bytes) + 24'(half_glyph_total) * 24'(gtl_pkg::HALF_STRIDE)
              + 24'(full_id) * 24'(gtl_pkg::FULL_STRIDE);
    full_off1 = full_off0 + 24'(gtl_pkg::HALF_STRIDE);
    tok_rel   = token_byte - ascii_base;
    half_off  = 24'(store_header_bytes) + 24'(tok_rel) * 24'(gtl_pkg::HALF_STRIDE);

    col_b    = {1'b0, cursor_col} + 9'd1;
    row_ok   = cursor_row < 8'(gtl_pkg::GRID_ROWS);
    col_a_ok = cursor_col < 8'(gtl_pkg::GRID_COLS);
    col_b_ok = col_b < 9'(gtl_pkg::GRID_COLS);

    place_a = (do_full || is_half) && row_ok && col_a_ok && slot_count < 9'(GLYPH_SLOTS);
    slot_a  = slot_count + 9'(place_a);
    place_b = do_full && row_ok && col_b_ok && slot_a < 9'(GLYPH_SLOTS);

    res_a.glyph_byte_offset = do_full ? full_off0 : half_off;
    res_a.slot_tile         = tile_of(slot_count);
    res_a.map_position      = {cursor_row[4:0], cursor_col[4:0]};
    res_a.last              = !place_b;

    res_b.glyph_byte_offset = full_off1;
    res_b.slot_tile         = tile_of(slot_a);
    res_b.map_position      = {cursor_row[4:0], col_b[4:0]};
    res_b.last              = 1'b1;

    push.r0    = place_a ? res_a : res_b;
    push.r1    = res_b;
    push.count = accept ? 2'(place_a) + 2'(place_b) : 2'd0;

    cursor_row_next     = cursor_row;
    cursor_col_next     = cursor_col;
    line_start_col_next = line_start_col;
    wide_pending_next   = wide_pending;
    wide_high_bits_next = wide_high_bits;
    slot_count_next     = slot_count;
    case (operation)
      gtl_pkg::OP_PAGE: begin
        slot_count_next = 9'd0;
      end
      gtl_pkg::OP_STRING: begin
        cursor_row_next     = {3'd0, start_row};
        cursor_col_next     = {3'd0, start_col};
        line_start_col_next = start_col;
        wide_pending_next   = 1'b0;
      end
      gtl_pkg::OP_TOKEN: begin
        slot_count_next = slot_a + 9'(place_b);
        if (do_full) begin
          wide_pending_next = 1'b0;
          cursor_col_next   = sat_add(cursor_col, 8'd2);
        end else if (is_nl) begin
          cursor_row_next = sat_add(cursor_row, {4'd0, line_pitch_tiles});
          cursor_col_next = {3'd0, line_start_col};
        end else if (is_wide_start) begin
          wide_pending_next   = 1'b1;
          wide_high_bits_next = token_byte[5:0] & gtl_pkg::HIGH_ID_MASK;
        end else if (is_half) begin
          cursor_col_next = sat_add(cursor_col, 8'd1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row     <= 8'd0;
      cursor_col     <= 8'd0;
      line_start_col <= 5'd0;
      wide_pending   <= 1'b0;
      wide_high_bits <= 6'd0;
      slot_count     <= 9'd0;
    end else if (accept) begin
      cursor_row     <= cursor_row_next;
      cursor_col     <= cursor_col_next;
      line_start_col <= line_start_col_next;
      wide_pending   <= wide_pending_next;
      wide_high_bits <= wide_high_bits_next;
      slot_count     <= slot_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_header_bytes <= 16'd0;
      half_glyph_total   <= 16'd0;
      newline_code       <= 8'd1;
      wide_flag_mask     <= 8'd128;
      ascii_base         <= 8'd32;
      line_pitch_tiles   <= 4'd2;
    end else if (cfg_en) begin
      case (cfg_index)
        gtl_pkg::REG_STORE_HEADER: store_header_bytes <= cfg_data;
        gtl_pkg::REG_HALF_TOTAL:   half_glyph_total   <= cfg_data;
        gtl_pkg::REG_NEWLINE:      newline_code       <= cfg_data[7:0];
        gtl_pkg::REG_WIDE_MASK:    wide_flag_mask     <= cfg_data[7:0];
        gtl_pkg::REG_ASCII_BASE:   ascii_base         <= cfg_data[7:0];
        gtl_pkg::REG_LINE_PITCH:   line_pitch_tiles   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### src/gtl_queue.sv
// ----------------------------------------------------------------------------
// gtl_queue
// Result queue taking up to two results per cycle, draining one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module gtl_queue (
  input  logic              clk,
  input  logic              rst,
  input  gtl_pkg::push_t    push,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output gtl_pkg::result_t  head
);

  localparam int AW = gtl_pkg::QUEUE_AW;

  gtl_pkg::result_t mem [gtl_pkg::QUEUE_DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [AW:0]   count, count_next;
  logic          pop;

  assign pop        = out_valid && !out_stall;
  assign out_valid  = count != '0;
  assign full       = count > (AW+1)'(gtl_pkg::QUEUE_DEPTH - 2);
  assign head       = mem[rd_ptr];
  assign count_next = count + (AW+1)'(push.count) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + AW'(pop);
      wr_ptr <= wr_ptr + AW'(push.count);
      count  <= count_next;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glyph_token_tile_layout. Token streams go in under
// several register settings, from the reset values to both extremes and
// random ones. A predictor in the bench tracks cursor, wide-glyph and slot
// state and queues the halfcells it expects; every output transaction is
// compared field by field, with random idling on the input and stalls on
// the output.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         SLOT_LIMIT = gtl_pkg::GLYPH_SLOTS_DEF;

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         cfg_en     = 1'b0;
  logic [gtl_pkg::CFG_AW-1:0]   cfg_index  = '0;
  logic [gtl_pkg::CFG_DW-1:0]   cfg_data   = '0;
  logic                         in_valid   = 1'b0;
  logic                         in_stall;
  logic [1:0]                   operation  = gtl_pkg::OP_PAGE;
  logic [4:0]                   start_row  = '0;
  logic [4:0]                   start_col  = '0;
  logic [7:0]                   token_byte = '0;
  logic                         out_valid;
  logic                         out_stall  = 1'b0;
  logic [23:0]                  glyph_byte_offset;
  logic [9:0]                   slot_tile;
  logic [9:0]                   map_position;
  logic                         last;

  // register copies
  logic [15:0] hdr_bytes;
  logic [15:0] half_glyphs;
  logic [7:0]  nl_code;
  logic [7:0]  wide_mask;
  logic [7:0]  base_code;
  logic [3:0]  pitch;

  // layout state copies
  logic [7:0]  pen_row;
  logic [7:0]  pen_col;
  logic [4:0]  line_home;
  logic        wide_wait;
  logic [5:0]  wide_hi;
  logic [8:0]  slots_used;

  gtl_pkg::result_t expected_glyphs[$];
  gtl_pkg::result_t want;

  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int gap_pct       = 0;
  int stall_pct     = 0;
  int stall_left    = 0;
  bit calm          = 1'b0;

  glyph_token_tile_layout #(.GLYPH_SLOTS(SLOT_LIMIT)) i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_en            (cfg_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .start_row         (start_row),
    .start_col         (start_col),
    .token_byte        (token_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .glyph_byte_offset (glyph_byte_offset),
    .slot_tile         (slot_tile),
    .map_position      (map_position),
    .last              (last)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] sat_step(logic [7:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 255) ? 8'hff : s[7:0];
  endfunction

  function automatic logic [23:0] wide_offset(logic [13:0] id, int unsigned second);
    int unsigned v;
    v = hdr_bytes + (half_glyphs * 2 + id * 4 + second * 2) * gtl_pkg::TILE_BYTES;
    return v[23:0];
  endfunction

  function automatic bit place_halfcell(int unsigned offset, int unsigned row,
                                        int unsigned col, output gtl_pkg::result_t r);
    int unsigned tile;
    int unsigned pos;
    r = '0;
    if (row >= gtl_pkg::GRID_ROWS || col >= gtl_pkg::GRID_COLS) return 1'b0;
    if (slots_used >= SLOT_LIMIT) return 1'b0;
    tile = 2 + slots_used * 2;
    pos  = row * gtl_pkg::GRID_COLS + col;
    r.glyph_byte_offset = offset[23:0];
    r.slot_tile         = tile[9:0];
    r.map_position      = pos[9:0];
    slots_used          = slots_used + 9'd1;
    return 1'b1;
  endfunction

  function automatic void predict_layout(logic [1:0] op, logic [4:0] row,
                                         logic [4:0] col, logic [7:0] tok);
    gtl_pkg::result_t got[2];
    gtl_pkg::result_t r;
    int               n;
    logic [13:0]      id;
    int unsigned      off;
    n = 0;
    case (op)
      gtl_pkg::OP_PAGE: slots_used = '0;
      gtl_pkg::OP_STRING: begin
        pen_row   = {3'b0, row};
        pen_col   = {3'b0, col};
        line_home = col;
        wide_wait = 1'b0;
      end
      gtl_pkg::OP_TOKEN: begin
        if (wide_wait) begin
          id        = {wide_hi, tok};
          wide_wait = 1'b0;
          if (place_halfcell(wide_offset(id, 0), pen_row, pen_col, r)) begin
            got[n] = r;
            n++;
          end
          if (place_halfcell(wide_offset(id, 1), pen_row, pen_col + 1, r)) begin
            got[n] = r;
            n++;
          end
          pen_col = sat_step(pen_col, 2);
        end else if (tok == 8'd0) begin
          // end-of-string mark
        end else if (tok == nl_code) begin
          pen_row = sat_step(pen_row, pitch);
          pen_col = {3'b0, line_home};
        end else if ((tok & wide_mask) != 8'd0) begin
          wide_wait = 1'b1;
          wide_hi   = tok[5:0];
        end else if (tok >= base_code) begin
          off = hdr_bytes + (tok - base_code) * 2 * gtl_pkg::TILE_BYTES;
          if (place_halfcell(off, pen_row, pen_col, r)) begin
            got[n] = r;
            n++;
          end
          pen_col = sat_step(pen_col, 1);
        end
      end
      default: ;
    endcase
    if (n > 0) got[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_glyphs.push_back(got[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_glyphs.size() == 0) begin
        $display("%0t: expected no result, actual offset %h tile %0d pos %0d last %b",
                 $time, glyph_byte_offset, slot_tile, map_position, last);
        errors++;
      end else begin
        want = expected_glyphs.pop_front();
        if (glyph_byte_offset !== want.glyph_byte_offset) begin
          $display("%0t: glyph_byte_offset expected %h actual %h",
                   $time, want.glyph_byte_offset, glyph_byte_offset);
          errors++;
        end
        if (slot_tile !== want.slot_tile) begin
          $display("%0t: slot_tile expected %0d actual %0d",
                   $time, want.slot_tile, slot_tile);
          errors++;
        end
        if (map_position !== want.map_position) begin
          $display("%0t: map_position expected %0d actual %0d",
                   $time, want.map_position, map_position);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last);
          errors++;
        end
        results_seen++;
      end
    end
  end

  // random output stall bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [1:0] op, input logic [4:0] row,
                           input logic [4:0] col, input logic [7:0] tok);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    operation  <= op;
    start_row  <= row;
    start_col  <= col;
    token_byte <= tok;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_layout(op, row, col, tok);
    items_sent++;
  endtask

  task automatic send_token(input logic [7:0] tok);
    send_item(gtl_pkg::OP_TOKEN, 5'($urandom), 5'($urandom), tok);
  endtask

  task automatic send_string(input logic [4:0] row, input logic [4:0] col);
    send_item(gtl_pkg::OP_STRING, row, col, 8'($urandom));
  endtask

  task automatic send_page();
    send_item(gtl_pkg::OP_PAGE, 5'($urandom), 5'($urandom), 8'($urandom));
  endtask

  // block idle: no transaction pending, every expected result delivered
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [gtl_pkg::CFG_AW-1:0] idx,
                         input logic [gtl_pkg::CFG_DW-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      gtl_pkg::REG_STORE_HEADER: hdr_bytes   = val;
      gtl_pkg::REG_HALF_TOTAL:   half_glyphs = val;
      gtl_pkg::REG_NEWLINE:      nl_code     = val[7:0];
      gtl_pkg::REG_WIDE_MASK:    wide_mask   = val[7:0];
      gtl_pkg::REG_ASCII_BASE:   base_code   = val[7:0];
      gtl_pkg::REG_LINE_PITCH:   pitch       = val[3:0];
      default: ;
    endcase
  endtask

  task automatic load_registers(input logic [15:0] h, input logic [15:0] ht,
                                input logic [7:0] nl, input logic [7:0] wm,
                                input logic [7:0] ab, input logic [3:0] lp);
    put_reg(gtl_pkg::REG_STORE_HEADER, h);
    put_reg(gtl_pkg::REG_HALF_TOTAL, ht);
    put_reg(gtl_pkg::REG_NEWLINE, {8'd0, nl});
    put_reg(gtl_pkg::REG_WIDE_MASK, {8'd0, wm});
    put_reg(gtl_pkg::REG_ASCII_BASE, {8'd0, ab});
    put_reg(gtl_pkg::REG_LINE_PITCH, {12'd0, lp});
    cfg_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] halfwidth_token();
    logic [7:0] t;
    t = 8'($urandom_range(base_code, 255));
    return t & ~wide_mask;
  endfunction

  function automatic logic [7:0] wide_lead_token();
    logic [7:0] t;
    t = 8'($urandom);
    if (wide_mask != 8'd0) t = t | (wide_mask & (~wide_mask + 8'd1));
    return t;
  endfunction

  // one string: optional page start, origin, a run of tokens, optional end mark
  task automatic send_sentence();
    int len;
    int k;
    if ($urandom_range(0, 9) == 0) send_page();
    if ($urandom_range(0, 9) == 0) send_string(5'($urandom_range(23, 31)), 5'($urandom));
    else send_string(5'($urandom_range(0, 22)), 5'($urandom));
    len = $urandom_range(1, 20);
    repeat (len) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        send_token(halfwidth_token());
      end else if (k < 72) begin
        send_token(nl_code);
      end else if (k < 90) begin
        send_token(wide_lead_token());
        send_token(8'($urandom));
      end else if (k < 95) begin
        send_token(8'($urandom));
      end else begin
        send_item($urandom_range(0, 1) ? OP_SPARE : gtl_pkg::OP_STRING, 5'($urandom),
                  5'($urandom), 8'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 0) send_token(8'd0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_defaults();
    send_page();
    send_string(5'd0, 5'd0);
    send_token(8'd65);
    send_token(8'd32);        // lowest halfwidth id
    send_token(8'd31);        // below base, ignored
    send_token(8'd0);         // end mark
    send_token(8'hff);        // wide lead, high bits all ones
    send_token(8'hff);        // low byte completes the largest id
    send_token(8'h80);        // wide lead, high bits zero
    send_token(8'd0);         // zero taken as low byte
    send_token(8'd1);         // newline
    send_token(8'd127);
    send_item(OP_SPARE, 5'h1f, 5'h1f, 8'hff);
    send_string(5'd22, 5'd31);
    send_token(8'hc1);
    send_token(8'd1);         // right half falls off the grid
    send_token(8'd66);
    send_string(5'd31, 5'd31);
    send_token(8'd66);
    send_string(5'd21, 5'd5);
    send_token(8'h85);
    send_string(5'd21, 5'd6); // drops the pending wide lead
    send_token(8'd67);
    send_token(8'd1);         // row 23, below the grid
    send_token(8'd68);
  endtask

  task automatic test_random_text(input int count, input int gaps, input int stalls);
    int stop;
    stop      = items_sent + count;
    gap_pct   = gaps;
    stall_pct = stalls;
    while (items_sent < stop) begin
      if ($urandom_range(0, 7) == 0) begin
        gap_pct   = $urandom_range(0, 1) ? 0 : gaps;
        stall_pct = $urandom_range(0, 1) ? 0 : stalls;
      end
      send_sentence();
    end
  endtask

  task automatic test_register_extremes();
    settle_block();
    load_registers(16'hffff, 16'hffff, 8'hff, 8'h01, 8'h00, 4'd8);
    send_page();
    send_string(5'd0, 5'd0);
    send_token(8'h02);
    send_token(8'h03);
    send_token(8'hff);
    send_token(8'hff);
    test_random_text(120, 25, 25);
    settle_block();
    load_registers(16'h0000, 16'h0000, 8'h00, 8'h00, 8'hff, 4'd1);
    send_page();
    send_string(5'd3, 5'd0);
    send_token(8'hff);
    send_token(8'hfe);
    send_token(8'h80);
    test_random_text(120, 25, 25);
  endtask

  // col and row driven past the grid until both saturate
  task automatic test_cursor_runaway();
    settle_block();
    load_registers(16'($urandom), 16'($urandom), 8'd10, 8'h80, 8'd32, 4'd8);
    send_page();
    send_string(5'd0, 5'($urandom_range(0, 31)));
    repeat (260) send_token(8'($urandom_range(33, 126)));
    send_token(8'h9a);
    send_token(8'($urandom));
    repeat (34) send_token(8'd10);
    send_token(8'd70);
    send_string(5'd2, 5'd4);
    send_token(8'd71);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      settle_block();
      load_registers(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     $urandom_range(0, 1) ? 8'($urandom_range(0, 64)) :
                                            8'($urandom_range(0, 255)),
                     4'($urandom_range(1, 8)));
      test_random_text(100, 30, 30);
    end
  endtask

  task automatic test_calm_finish();
    settle_block();
    load_registers(16'($urandom), 16'($urandom), 8'd1, 8'h80, 8'd32,
                   4'($urandom_range(1, 8)));
    calm = 1'b1;
    test_random_text(150, 0, 0);
  endtask

  initial begin
    hdr_bytes   = '0;
    half_glyphs = '0;
    nl_code     = 8'd1;
    wide_mask   = 8'd128;
    base_code   = 8'd32;
    pitch       = 4'd2;
    pen_row     = '0;
    pen_col     = '0;
    line_home   = '0;
    wide_wait   = 1'b0;
    wide_hi     = '0;
    slots_used  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_random_text(150, 20, 20);
    test_register_extremes();
    test_cursor_runaway();
    test_random_settings();
    test_calm_finish();

    settle_block();
    repeat (20) @(posedge clk);
    $display("covered %0d input transactions over %0d register settings,", items_sent,
             settings_used + 1);
    $display("with %0d halfcell results checked under random idling and stalls",
             results_seen);
    if (errors == 0 && expected_glyphs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
